// ===== design/isqrt_pkg.sv =====
// Shared types for the integer square root core.
// No dependencies; imported by the stage and top-level modules.
package isqrt_pkg;

   localparam int unsigned STEP_BITS = 2;

   typedef struct packed {
      logic valid;
      logic negative;
   } isqrt_ctl_type;

endpackage

// ===== design/isqrt_req_if.sv =====
// Request channel: valid/ready handshake carrying one signed operand.
// No dependencies.
interface isqrt_req_if #(
   parameter int unsigned DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] operand;

   modport source (output valid, output operand, input ready);
   modport sink   (input valid, input operand, output ready);
endinterface

// ===== design/isqrt_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one signed root.
// No dependencies.
interface isqrt_rsp_if #(
   parameter int unsigned ROOT_WIDTH = 17
);
   logic                         valid;
   logic                         ready;
   logic signed [ROOT_WIDTH-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

// ===== design/isqrt_stage.sv =====
// One restoring square root step: brings in two operand bits, resolves one root bit.
// Registered stage with local valid/ready; depends on isqrt_pkg.
module isqrt_stage
   import isqrt_pkg::*;
#(
   parameter int unsigned PAIRS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  isqrt_ctl_type        in_ctl,
   input  logic [PAIRS+1:0]     in_rem,
   input  logic [PAIRS-1:0]     in_root,
   input  logic [2*PAIRS-1:0]   in_x,
   output logic                 in_ready,
   output isqrt_ctl_type        out_ctl,
   output logic [PAIRS+1:0]     out_rem,
   output logic [PAIRS-1:0]     out_root,
   output logic [2*PAIRS-1:0]   out_x,
   input  logic                 out_ready
);
   localparam int unsigned REM_W = PAIRS + 2;
   localparam int unsigned X_W   = 2 * PAIRS;

   isqrt_ctl_type    ctl_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [PAIRS-1:0] root_ff, root_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] diff;
   logic             fits;

   always_comb begin
      rem_shift = {in_rem[REM_W-STEP_BITS-1:0], in_x[X_W-1 -: STEP_BITS]};
      trial     = {in_root, 2'b01};
      diff      = rem_shift - trial;
      fits      = (rem_shift >= trial);
      rem_in    = fits ? diff : rem_shift;
      root_in   = {in_root[PAIRS-2:0], fits};
      x_in      = in_x << STEP_BITS;
   end

   assign in_ready = !ctl_ff.valid || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         x_ff    <= x_in;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_x    = x_ff;
endmodule

// ===== design/integer_square_root_core.sv =====
// Integer square root core: pipelined restoring square root, one root bit per stage.
// Depends on isqrt_pkg, isqrt_req_if, isqrt_rsp_if and isqrt_stage.
//
// Usage:
//   req_if carries a signed DATA_WIDTH-bit operand; rsp_if returns a signed
//   root of (DATA_WIDTH+1)/2+1 bits, floor(sqrt(operand)), or all ones when
//   the operand is negative. One response beat per request beat, in order.
//   Each request beat passes through the chain of registered stages, one root bit each.
//   Throughput: one beat per cycle while rsp_if.ready stays high; every stage holds its own item.
//   Each stage stalls only while it holds an item and the next stage cannot
//   accept, so a stalled receiver fills the empty stages before req_if.ready
//   drops; nothing is lost or repeated.
//   Reset (synchronous, active high) empties every stage; there is no other
//   state to clear.
module integer_square_root_core
   import isqrt_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   isqrt_req_if.sink   req_if,
   isqrt_rsp_if.source rsp_if
);
   localparam int unsigned PAIRS  = (DATA_WIDTH + 1) / 2;
   localparam int unsigned REM_W  = PAIRS + 2;
   localparam int unsigned X_W    = 2 * PAIRS;

   isqrt_ctl_type    ctl   [PAIRS+1];
   logic [REM_W-1:0] rem   [PAIRS+1];
   logic [PAIRS-1:0] root  [PAIRS+1];
   logic [X_W-1:0]   x     [PAIRS+1];
   logic             ready [PAIRS+1];

   assign ctl[0].valid    = req_if.valid;
   assign ctl[0].negative = req_if.operand[DATA_WIDTH-1];
   assign rem[0]          = '0;
   assign root[0]         = '0;
   assign x[0]            = X_W'($unsigned(req_if.operand));
   assign req_if.ready    = ready[0];

   for (genvar i = 0; i < PAIRS; i++) begin : g_stage
      isqrt_stage #(
         .PAIRS (PAIRS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl[i]),
         .in_rem    (rem[i]),
         .in_root   (root[i]),
         .in_x      (x[i]),
         .in_ready  (ready[i]),
         .out_ctl   (ctl[i+1]),
         .out_rem   (rem[i+1]),
         .out_root  (root[i+1]),
         .out_x     (x[i+1]),
         .out_ready (ready[i+1])
      );
   end

   assign ready[PAIRS] = rsp_if.ready;
   assign rsp_if.valid = ctl[PAIRS].valid;
   assign rsp_if.root  = ctl[PAIRS].negative ? '1 : {1'b0, root[PAIRS]};

`ifndef SYNTHESIS
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> ctl[1].valid)
      else $error("accepted request beat did not reach the first stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !ctl[PAIRS].valid |-> req_if.ready)
      else $error("request stalled while the output stage is empty");

   a_remainder: assert property (@(posedge clock) disable iff (reset)
      ctl[PAIRS].valid && !ctl[PAIRS].negative |-> rem[PAIRS] <= {1'b0, root[PAIRS], 1'b0})
      else $error("final remainder exceeds twice the root");

   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.root[PAIRS] |-> &rsp_if.root)
      else $error("negative root other than minus one");
`endif
endmodule
